// ----- rtl/core/consistent_hash_ring_unit_assert.svh -----
// assertion macros for the hash ring unit
`ifndef CONSISTENT_HASH_RING_UNIT_ASSERT_SVH
`define CONSISTENT_HASH_RING_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CHR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define CHR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/chr_pkg.sv -----
// package for the hash ring unit: sizes, codes and controller states
package chr_pkg;
    localparam int RING_ENTRIES = 256;
    localparam int SERVER_BITS  = 8;
    localparam int HASH_BITS    = 32;
    localparam int ADDR_BITS    = $clog2(RING_ENTRIES);
    localparam int CNT_BITS     = ADDR_BITS + 1;
    localparam int ENTRY_BITS   = HASH_BITS + SERVER_BITS;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_DUP    = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_WAIT,
        S_DECIDE,
        S_FETCH,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;
endpackage

// ----- rtl/core/consistent_hash_ring_unit.sv -----
// top level of the hash ring unit: controller and entry memory
//
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   op, hash_value, node_index
// out      output     out_valid / out_stall server_index, status
//
// lookup does one memory read per search step
// insert and delete read and then write each shifted entry through the single ram port
// the entry count clears on reset; the ram holds no reset state
// the input stalls while busy and while the previous result still waits at the output
module consistent_hash_ring_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [chr_pkg::HASH_BITS-1:0] hash_value,
    input  logic [7:0]                    node_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    server_index,
    output logic [1:0]                    status
);
    import chr_pkg::*;

    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic [ENTRY_BITS-1:0] mem_wdata, mem_rdata;
    logic [CNT_BITS-1:0]   count;

    chr_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .op, .hash_value, .node_index,
        .out_valid, .out_stall, .server_index, .status,
        .mem_we, .mem_addr, .mem_wdata, .mem_rdata, .count
    );

    // hash and server stored together
    chr_ram #(.WIDTH(ENTRY_BITS), .DEPTH(RING_ENTRIES)) u_ram (
        .clk, .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
    );

`include "consistent_hash_ring_unit_assert.svh"

    `CHR_ASSERT_IMP(a_count_max, 1'b1, count <= CNT_BITS'(RING_ENTRIES))
    `CHR_ASSERT_NEXT(a_count_step, 1'b1, (count - $past(count) + 1'b1) <= CNT_BITS'(2))
    `CHR_ASSERT_IMP(a_ok_srv, out_valid && (status != ST_OK), server_index == 8'd0)
    `CHR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable({server_index,status}))
endmodule

// ----- rtl/core/chr_ram.sv -----
// generic single port ram with registered read
module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old entry on a write, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/core/chr_ctrl.sv -----
// sequencer: binary search, shift for insert and delete, result beat
module chr_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      op,
    input  logic [chr_pkg::HASH_BITS-1:0]   hash_value,
    input  logic [7:0]                      node_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      server_index,
    output logic [1:0]                      status,
    output logic                            mem_we,
    output logic [chr_pkg::ADDR_BITS-1:0]   mem_addr,
    output logic [chr_pkg::ENTRY_BITS-1:0]  mem_wdata,
    input  logic [chr_pkg::ENTRY_BITS-1:0]  mem_rdata,
    output logic [chr_pkg::CNT_BITS-1:0]    count
);
    import chr_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [CNT_BITS-1:0]   idx_reg, idx_next;
    logic [1:0]            op_reg, op_next;
    logic [HASH_BITS-1:0]  hash_reg, hash_next;
    logic [SERVER_BITS-1:0] srv_reg, srv_next;
    logic                  ov_reg, ov_next;
    logic [7:0]            sidx_reg, sidx_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  hit;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign hit = (lo_reg < count_reg) && (mem_rdata[ENTRY_BITS-1:SERVER_BITS] == hash_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        idx_reg  <= idx_next;
        op_reg   <= op_next;
        hash_reg <= hash_next;
        srv_reg  <= srv_next;
        sidx_reg <= sidx_next;
        stat_reg <= stat_next;
    end

    // next state and memory port
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        hash_next  = hash_reg;
        srv_next   = srv_reg;
        ov_next    = ov_reg;
        sidx_next  = sidx_reg;
        stat_next  = stat_reg;
        mem_we     = 1'b0;
        mem_addr   = mid[ADDR_BITS-1:0];
        mem_wdata  = {hash_reg, srv_reg};
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    op_next   = op;
                    hash_next = hash_value;
                    srv_next  = node_index[SERVER_BITS-1:0];
                    lo_next   = '0;
                    hi_next   = count_reg;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                // read mid, or finish with a read of lo (address 0 when lo has reached count)
                if (lo_reg < hi_reg)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    mem_addr   = (lo_reg < count_reg) ? lo_reg[ADDR_BITS-1:0] : '0;
                    state_next = S_DECIDE;
                end
            end
            S_WAIT:
            begin
                if (mem_rdata[ENTRY_BITS-1:SERVER_BITS] < hash_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SEARCH;
            end
            S_DECIDE:
            begin
                sidx_next  = '0;
                stat_next  = ST_OK;
                state_next = S_DONE;
                idx_next   = count_reg;
                case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next = ST_ABSENT;
                        end
                        else
                        begin
                            sidx_next = 8'(mem_rdata[SERVER_BITS-1:0]);
                        end
                    end
                    OP_INSERT:
                    begin
                        if (hit)
                        begin
                            stat_next = ST_DUP;
                        end
                        else if (count_reg == CNT_BITS'(RING_ENTRIES))
                        begin
                            stat_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (hit)
                        begin
                            idx_next   = lo_reg + 1'b1;
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            stat_next = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FETCH:
            begin
                // insert walks down from count, delete walks up from pos+1
                if (op_reg == OP_INSERT)
                begin
                    if (idx_reg > lo_reg)
                    begin
                        mem_addr   = ADDR_BITS'(idx_reg - 1'b1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    if (idx_reg < count_reg)
                    begin
                        mem_addr   = idx_reg[ADDR_BITS-1:0];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (op_reg == OP_INSERT)
                begin
                    mem_addr = idx_reg[ADDR_BITS-1:0];
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    mem_addr = ADDR_BITS'(idx_reg - 1'b1);
                    idx_next = idx_reg + 1'b1;
                end
                state_next = S_FETCH;
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_addr   = lo_reg[ADDR_BITS-1:0];
                mem_wdata  = {hash_reg, srv_reg};
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // input waits while busy or while a result beat is pending
    assign in_stall     = (state_reg != S_IDLE) || ov_reg;
    assign out_valid    = ov_reg;
    assign server_index = sidx_reg;
    assign status       = stat_reg;
    assign count        = count_reg;
endmodule
